@@ rtl/rwcts_pkg.sv @@
// Package for the textured wall column stepper.
// Field widths, status codes, and the controller/datapath command and status structs.
// No dependencies.
package rwcts_pkg;

    localparam int COL_W    = 11;
    localparam int DIST_W   = 24;
    localparam int FRAC_W   = 16;
    localparam int TSEL_W   = 2;
    localparam int TEX_W    = 11;
    localparam int OROW_W   = 10;
    localparam int STAT_W   = 2;
    localparam int OFF_W    = 22;
    localparam int LH_W     = 16;
    localparam int SPAN_W   = 17;
    localparam int TCOL_W   = 10;
    localparam int ACC_W    = 32;
    localparam int LIM_W    = 24;
    localparam int DVD_W    = 32;
    localparam int DVS_W    = 24;

    localparam int IN_TDATA_W  = 80;
    localparam int OUT_TDATA_W = 48;

    localparam logic MODE_COLUMN = 1'b0;
    localparam logic MODE_ROW    = 1'b1;

    typedef enum logic [STAT_W-1:0] {
        ST_OUTSIDE = 2'd0,
        ST_DRAWN   = 2'd1,
        ST_BEYOND  = 2'd2
    } t_status;

    typedef enum logic {
        DIV_LH,
        DIV_STEP
    } t_div_sel;

    typedef struct packed {
        logic     load_col;
        logic     div_start;
        t_div_sel div_sel;
        logic     lh_load;
        logic     limit_load;
        logic     step_load;
        logic     acc_mul;
        logic     acc_load;
        logic     row_mul;
        logic     row_eval;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic col_done;
    } t_sts;

endpackage

@@ rtl/rwcts_div.sv @@
// Restoring divider, one quotient bit per cycle.
// Depends on rwcts_pkg for operand widths.
module rwcts_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [rwcts_pkg::DVD_W-1:0]    i_dividend,
    input  logic [rwcts_pkg::DVS_W-1:0]    i_divisor,
    output logic                           o_done,
    output logic [rwcts_pkg::DVD_W-1:0]    o_quotient
);

    localparam int DVD_W = rwcts_pkg::DVD_W;
    localparam int DVS_W = rwcts_pkg::DVS_W;
    localparam int CNT_W = $clog2(DVD_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DVD_W-1:0] r_dvd;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;

    logic [DVS_W:0]   rem_sh;
    logic [DVS_W:0]   diff;
    logic             ge;

    // dividend shifts out the top while quotient bits shift in at the bottom
    assign rem_sh = {r_rem, r_dvd[DVD_W-1]};
    assign ge     = rem_sh >= {1'b0, r_dvs};
    assign diff   = ge ? (rem_sh - {1'b0, r_dvs}) : rem_sh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[DVD_W-2:0], ge};
            r_rem <= diff[DVS_W-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_dvd;

endmodule

@@ rtl/rwcts_dp.sv @@
// Datapath: column geometry registers, texture row accumulator, row evaluation, result word.
// Depends on rwcts_pkg and rwcts_div.
module rwcts_dp #(
    parameter int SCREEN_HEIGHT = 1024
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  rwcts_pkg::t_cmd                 i_cmd,
    input  logic [rwcts_pkg::COL_W-1:0]     i_column,
    input  logic [rwcts_pkg::DIST_W-1:0]    i_distance,
    input  logic [rwcts_pkg::FRAC_W-1:0]    i_wall_fraction,
    input  logic [rwcts_pkg::TSEL_W-1:0]    i_texture_select,
    input  logic [rwcts_pkg::TEX_W-1:0]     i_tex_width,
    input  logic [rwcts_pkg::TEX_W-1:0]     i_tex_height,
    output rwcts_pkg::t_sts                 o_sts,
    output logic [rwcts_pkg::COL_W-1:0]     o_out_column,
    output logic [rwcts_pkg::OROW_W-1:0]    o_out_row,
    output logic [rwcts_pkg::TSEL_W-1:0]    o_out_texture,
    output logic [rwcts_pkg::STAT_W-1:0]    o_status,
    output logic [rwcts_pkg::OFF_W-1:0]     o_texel_offset
);

    localparam int COL_W  = rwcts_pkg::COL_W;
    localparam int DIST_W = rwcts_pkg::DIST_W;
    localparam int FRAC_W = rwcts_pkg::FRAC_W;
    localparam int TSEL_W = rwcts_pkg::TSEL_W;
    localparam int TEX_W  = rwcts_pkg::TEX_W;
    localparam int OROW_W = rwcts_pkg::OROW_W;
    localparam int OFF_W  = rwcts_pkg::OFF_W;
    localparam int LH_W   = rwcts_pkg::LH_W;
    localparam int SPAN_W = rwcts_pkg::SPAN_W;
    localparam int TCOL_W = rwcts_pkg::TCOL_W;
    localparam int ACC_W  = rwcts_pkg::ACC_W;
    localparam int LIM_W  = rwcts_pkg::LIM_W;
    localparam int DVD_W  = rwcts_pkg::DVD_W;
    localparam int DVS_W  = rwcts_pkg::DVS_W;
    localparam int ROW_W  = $clog2(SCREEN_HEIGHT + 1);
    localparam int HALF   = SCREEN_HEIGHT / 2;
    localparam int TROW_W = ACC_W - 16;
    localparam int RMUL_W = TEX_W + TROW_W;
    localparam int TMUL_W = TEX_W + FRAC_W;
    localparam int AMUL_W = LH_W + ACC_W;
    localparam int XOFF_W = RMUL_W + 3;
    localparam int CMP_W  = SPAN_W + 1;
    localparam logic [DVD_W-1:0] LH_DVD = DVD_W'(SCREEN_HEIGHT * 4096);

    // column state
    logic [COL_W-1:0]         r_column;
    logic [TSEL_W-1:0]        r_texture;
    logic [TEX_W-1:0]         r_width;
    logic [TEX_W-1:0]         r_height;
    logic [DIST_W-1:0]        r_dist;
    logic [FRAC_W-1:0]        r_frac;
    logic [LH_W-1:0]          r_lh;
    logic signed [SPAN_W-1:0] r_span_start;
    logic [SPAN_W-1:0]        r_span_end;
    logic [TCOL_W-1:0]        r_tcol;
    logic [LIM_W-1:0]         r_limit;
    logic [ACC_W-1:0]         r_step;
    logic [ACC_W-1:0]         r_acc;
    logic [ROW_W-1:0]         r_row;

    // intermediate products
    logic [AMUL_W-1:0]        r_amul;
    logic [RMUL_W-1:0]        r_rmul;
    logic                     r_in_span;

    // result word
    logic [COL_W-1:0]         r_o_column;
    logic [OROW_W-1:0]        r_o_row;
    logic [TSEL_W-1:0]        r_o_texture;
    rwcts_pkg::t_status       r_o_status;
    logic [OFF_W-1:0]         r_o_offset;

    logic [DVD_W-1:0]         div_dvd;
    logic [DVS_W-1:0]         div_dvs;
    logic                     div_done;
    logic [DVD_W-1:0]         div_q;

    logic [LH_W-1:0]          lh_sat;
    logic [LH_W-2:0]          half_lh;
    logic [TMUL_W-1:0]        tmul;
    logic [2*TEX_W-1:0]       wh_prod;
    logic [LH_W-1:0]          neg_start;
    logic signed [CMP_W-1:0]  row_s;
    logic                     in_span;
    logic [XOFF_W-1:0]        off;
    logic                     beyond;
    logic [ACC_W:0]           acc_sum;

    assign div_dvd = (i_cmd.div_sel == rwcts_pkg::DIV_LH) ? LH_DVD
                   : DVD_W'({r_height, 16'h0000});
    assign div_dvs = (i_cmd.div_sel == rwcts_pkg::DIV_LH) ? r_dist : DVS_W'(r_lh);

    rwcts_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    // a zero divisor yields all ones, which covers both saturation cases
    assign lh_sat    = (|div_q[DVD_W-1:LH_W]) ? '1 : div_q[LH_W-1:0];
    assign half_lh   = lh_sat[LH_W-1:1];
    assign tmul      = r_frac * r_width;
    assign wh_prod   = r_width * r_height;
    assign neg_start = r_span_start[SPAN_W-1] ? LH_W'(-r_span_start) : '0;

    assign row_s   = CMP_W'(r_row);
    assign in_span = (row_s >= CMP_W'(r_span_start)) && (row_s <= $signed({1'b0, r_span_end}));

    assign off     = {1'b0, r_rmul, 2'b00} + XOFF_W'({r_tcol, 2'b00});
    assign beyond  = off >= XOFF_W'(r_limit);
    assign acc_sum = {1'b0, r_acc} + {1'b0, r_step};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column     <= '0;
            r_texture    <= '0;
            r_width      <= TEX_W'(1);
            r_height     <= TEX_W'(1);
            r_lh         <= '0;
            r_span_start <= '0;
            r_span_end   <= '0;
            r_tcol       <= '0;
            r_limit      <= LIM_W'(4);
            r_step       <= '0;
            r_acc        <= '0;
            r_row        <= '0;
        end else begin
            if (i_cmd.load_col) begin
                r_column  <= i_column;
                r_texture <= i_texture_select;
                r_width   <= i_tex_width;
                r_height  <= i_tex_height;
            end
            if (i_cmd.lh_load) begin
                r_lh         <= lh_sat;
                r_span_start <= $signed(SPAN_W'(HALF)) - $signed(SPAN_W'(half_lh));
                r_span_end   <= SPAN_W'(HALF) + SPAN_W'(half_lh);
            end
            if (i_cmd.limit_load) begin
                r_tcol  <= tmul[FRAC_W +: TCOL_W];
                r_limit <= {wh_prod, 2'b00};
            end
            if (i_cmd.step_load) begin
                r_step <= div_q;
            end
            if (i_cmd.acc_load) begin
                r_acc <= (|r_amul[AMUL_W-1:ACC_W]) ? '1 : r_amul[ACC_W-1:0];
                r_row <= '0;
            end
            if (i_cmd.row_eval) begin
                if (r_in_span && !beyond) begin
                    r_acc <= acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];
                end
                r_row <= r_row + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_col) begin
            r_dist <= i_distance;
            r_frac <= i_wall_fraction;
        end
        if (i_cmd.acc_mul) begin
            r_amul <= neg_start * r_step;
        end
        if (i_cmd.row_mul) begin
            r_rmul    <= r_width * r_acc[ACC_W-1:16];
            r_in_span <= in_span;
        end
        if (i_cmd.row_eval) begin
            r_o_column  <= r_column;
            r_o_row     <= OROW_W'(r_row);
            r_o_texture <= r_texture;
            if (!r_in_span) begin
                r_o_status <= rwcts_pkg::ST_OUTSIDE;
                r_o_offset <= '0;
            end else if (beyond) begin
                r_o_status <= rwcts_pkg::ST_BEYOND;
                r_o_offset <= '0;
            end else begin
                r_o_status <= rwcts_pkg::ST_DRAWN;
                r_o_offset <= off[OFF_W-1:0];
            end
        end
    end

    assign o_sts.div_done = div_done;
    assign o_sts.col_done = r_row >= ROW_W'(SCREEN_HEIGHT);

    assign o_out_column   = r_o_column;
    assign o_out_row      = r_o_row;
    assign o_out_texture  = r_o_texture;
    assign o_status       = r_o_status;
    assign o_texel_offset = r_o_offset;

endmodule

@@ rtl/rwcts_ctrl.sv @@
// Controller: sequences column setup (two divisions, products) and row evaluation,
// and owns the input ready and result valid. Depends on rwcts_pkg.
module rwcts_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_mode,
    input  logic              i_out_ready,
    input  rwcts_pkg::t_sts   i_sts,
    output logic              o_in_ready,
    output logic              o_out_valid,
    output rwcts_pkg::t_cmd   o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_LH_START,
        S_LH_WAIT,
        S_STEP_START,
        S_STEP_WAIT,
        S_ACC_MUL,
        S_ACC_LOAD,
        S_ROW_MUL,
        S_ROW_EVAL
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_in_mode == rwcts_pkg::MODE_COLUMN) begin
                        o_cmd.load_col = 1'b1;
                        n_state        = S_LH_START;
                    end else if (!i_sts.col_done) begin
                        n_state = S_ROW_MUL;
                    end
                end
            end
            S_LH_START: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = rwcts_pkg::DIV_LH;
                n_state         = S_LH_WAIT;
            end
            S_LH_WAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.lh_load = 1'b1;
                    n_state       = S_STEP_START;
                end
            end
            S_STEP_START: begin
                o_cmd.div_start  = 1'b1;
                o_cmd.div_sel    = rwcts_pkg::DIV_STEP;
                o_cmd.limit_load = 1'b1;
                n_state          = S_STEP_WAIT;
            end
            S_STEP_WAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.step_load = 1'b1;
                    n_state         = S_ACC_MUL;
                end
            end
            S_ACC_MUL: begin
                o_cmd.acc_mul = 1'b1;
                n_state       = S_ACC_LOAD;
            end
            S_ACC_LOAD: begin
                o_cmd.acc_load = 1'b1;
                n_state        = S_IDLE;
            end
            S_ROW_MUL: begin
                o_cmd.row_mul = 1'b1;
                n_state       = S_ROW_EVAL;
            end
            S_ROW_EVAL: begin
                // result register must be free or draining this cycle
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.row_eval = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.row_eval) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

@@ rtl/raycast_wall_column_texel_stepper_unit.sv @@
// Top level of the textured wall column stepper: stream ports, field packing,
// controller and datapath. Depends on rwcts_pkg, rwcts_ctrl, rwcts_dp.
//
// A begin-column word (tuser = 0) latches the column, texture and size and derives the
// wall slice: line height = SCREEN_HEIGHT*4096/distance, span, texture column, Q16.16
// step and start row. Each row word (tuser = 1) then yields one result word for the next
// screen row until SCREEN_HEIGHT rows are done; later row words give nothing. Items are
// worked one at a time: a row word goes from accept through the texel row multiply to
// the offset add and bound compare, which waits while the output register is full and not
// draining. A begin-column word runs two passes through the shared one-bit-per-cycle
// divider (line height, then step) plus the start-row multiply. Input is accepted again
// while a result still waits in the output register.
module raycast_wall_column_texel_stepper_unit #(
    parameter int SCREEN_HEIGHT = 1024
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    // column[10:0], distance[34:11], wall_fraction[50:35], texture_select[52:51],
    // tex_width[63:53], tex_height[74:64], zero[79:75]
    input  logic [rwcts_pkg::IN_TDATA_W-1:0]      i_s_axis_tdata,
    // mode[0]
    input  logic                                  i_s_axis_tuser,
    output logic                                  o_m_axis_tvalid,
    input  logic                                  i_m_axis_tready,
    // out_column[10:0], out_row[20:11], out_texture[22:21], texel_offset[44:23], zero[47:45]
    output logic [rwcts_pkg::OUT_TDATA_W-1:0]     o_m_axis_tdata,
    // status[1:0]
    output logic [rwcts_pkg::STAT_W-1:0]          o_m_axis_tuser
);

    rwcts_pkg::t_cmd cmd;
    rwcts_pkg::t_sts sts;

    logic [rwcts_pkg::COL_W-1:0]  out_column;
    logic [rwcts_pkg::OROW_W-1:0] out_row;
    logic [rwcts_pkg::TSEL_W-1:0] out_texture;
    logic [rwcts_pkg::OFF_W-1:0]  texel_offset;

    rwcts_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .i_in_mode   (i_s_axis_tuser),
        .i_out_ready (i_m_axis_tready),
        .i_sts       (sts),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_cmd       (cmd)
    );

    rwcts_dp #(
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_column         (i_s_axis_tdata[10:0]),
        .i_distance       (i_s_axis_tdata[34:11]),
        .i_wall_fraction  (i_s_axis_tdata[50:35]),
        .i_texture_select (i_s_axis_tdata[52:51]),
        .i_tex_width      (i_s_axis_tdata[63:53]),
        .i_tex_height     (i_s_axis_tdata[74:64]),
        .o_sts            (sts),
        .o_out_column     (out_column),
        .o_out_row        (out_row),
        .o_out_texture    (out_texture),
        .o_status         (o_m_axis_tuser),
        .o_texel_offset   (texel_offset)
    );

    assign o_m_axis_tdata = {3'b000, texel_offset, out_texture, out_row, out_column};

endmodule
